>>> hdl/tscu_pkg.sv
// types, constants and helpers shared by the text stream statistics counter
package tscu_pkg;

	localparam int REPORT_W         = 32;
	localparam int WINDOW_MAX_BYTES = 8;
	localparam int PATTERN_W        = 8 * WINDOW_MAX_BYTES;
	localparam int ENABLES_W        = 4;
	localparam int LENGTH_W         = 4;
	localparam int CFG_INDEX_W      = 2;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0a;
	localparam logic [7:0] SPACE_BYTE   = 8'h20;
	localparam logic [7:0] TAB_BYTE     = 8'h09;
	localparam logic [7:0] CR_BYTE      = 8'h0d;

	localparam int EN_CHARS_BIT = 0;
	localparam int EN_WORDS_BIT = 1;
	localparam int EN_LINES_BIT = 2;
	localparam int EN_BLANK_BIT = 3;

	typedef enum logic {
		CMD_BYTE   = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COUNT_ENABLES  = 2'd0,
		CFG_PATTERN_LENGTH = 2'd1,
		CFG_PATTERN_BYTES  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic       step;
		logic       clear;
		logic [7:0] data;
	} trk_req_t;

	typedef struct packed {
		logic word_end;
		logic score;
	} trk_evt_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == SPACE_BYTE) || (b inside {[TAB_BYTE:CR_BYTE]});
	endfunction

endpackage

>>> hdl/text_stream_statistics_counter_unit.sv
// Text stream statistics counter: one request (a text byte or a finish) is taken
// per clock into an input register and applied to the counters by a single
// update pass of compares and increments in the next cycle, so a steady stream
// runs at one byte per cycle. A finish passes from the input register to the result
// register, where it places all counts, and clears the counting state in the same cycle;
// the input side stalls only while a finish waits behind a report not yet taken.
// Configuration writes are taken every cycle and apply at once.
module text_stream_statistics_counter_unit #(
	parameter int PATTERN_MAX = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [7:0]                         text_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tscu_pkg::REPORT_W-1:0]      char_count,
	output logic [tscu_pkg::REPORT_W-1:0]      line_count,
	output logic [tscu_pkg::REPORT_W-1:0]      word_count,
	output logic [tscu_pkg::REPORT_W-1:0]      blank_line_count,
	output logic [tscu_pkg::REPORT_W-1:0]      filled_line_count,
	output logic [tscu_pkg::REPORT_W-1:0]      pattern_score,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tscu_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tscu_pkg::PATTERN_W-1:0]     cfg_data
);

	localparam int WIN_BYTES = (PATTERN_MAX < tscu_pkg::WINDOW_MAX_BYTES) ?
		PATTERN_MAX : tscu_pkg::WINDOW_MAX_BYTES;
	localparam int RW = tscu_pkg::REPORT_W;

	logic [tscu_pkg::ENABLES_W-1:0] en_q;
	logic [tscu_pkg::LENGTH_W-1:0]  len_q;
	logic [tscu_pkg::PATTERN_W-1:0] pat_q;

	logic           valid_s1;
	tscu_pkg::cmd_t cmd_s1;
	logic [7:0]     byte_s1;
	logic [7:0]     last_line_q;

	logic out_valid_q;
	logic [RW-1:0] char_q, line_q, word_q, blank_q, filled_q, score_q;

	logic s1_adv, s1_fire, step, fin, in_fire;
	logic en_lines, is_nl;

	tscu_pkg::trk_req_t trk_req;
	tscu_pkg::trk_evt_t trk_evt;

	logic [COUNT_WIDTH-1:0] chars_cnt, lines_cnt, words_cnt, blank_cnt, score_cnt;
	logic [RW-1:0] chars_rpt, lines_rpt, words_rpt, blank_rpt, score_rpt;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= '1;
			len_q <= '0;
			pat_q <= '0;
		end else if (cfg_valid) begin
			case (tscu_pkg::cfg_idx_t'(cfg_index))
				tscu_pkg::CFG_COUNT_ENABLES:  en_q  <= cfg_data[tscu_pkg::ENABLES_W-1:0];
				tscu_pkg::CFG_PATTERN_LENGTH: len_q <= cfg_data[tscu_pkg::LENGTH_W-1:0];
				tscu_pkg::CFG_PATTERN_BYTES:  pat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign s1_adv   = (cmd_s1 != tscu_pkg::CMD_FINISH) || !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_adv;
	assign in_fire  = in_valid && in_ready;
	assign s1_fire  = valid_s1 && s1_adv;
	assign step     = s1_fire && (cmd_s1 == tscu_pkg::CMD_BYTE);
	assign fin      = s1_fire && (cmd_s1 == tscu_pkg::CMD_FINISH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1  <= tscu_pkg::CMD_BYTE;
			byte_s1 <= '0;
		end else if (in_fire) begin
			cmd_s1  <= tscu_pkg::cmd_t'(cmd);
			byte_s1 <= text_byte;
		end
	end

	// line tracking
	assign en_lines = en_q[tscu_pkg::EN_LINES_BIT];
	assign is_nl    = byte_s1 == tscu_pkg::NEWLINE_BYTE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_line_q <= '0;
		end else if (fin) begin
			last_line_q <= '0;
		end else if (step && en_lines) begin
			last_line_q <= byte_s1;
		end
	end

	// word and pattern tracking
	assign trk_req.step  = step;
	assign trk_req.clear = fin;
	assign trk_req.data  = byte_s1;

	tscu_word_track #(
		.WIN_BYTES(WIN_BYTES)
	) u_word_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (trk_req),
		.en_words      (en_q[tscu_pkg::EN_WORDS_BIT]),
		.pattern_length(len_q),
		.pattern       (pat_q),
		.evt           (trk_evt)
	);

	// counters
	tscu_sat_counter #(.WIDTH(COUNT_WIDTH)) u_chars (
		.clk(clk), .arst_n(arst_n),
		.inc(step && en_q[tscu_pkg::EN_CHARS_BIT]), .clr(fin),
		.count(chars_cnt), .report(chars_rpt)
	);

	tscu_sat_counter #(.WIDTH(COUNT_WIDTH)) u_lines (
		.clk(clk), .arst_n(arst_n),
		.inc(step && en_lines && is_nl), .clr(fin),
		.count(lines_cnt), .report(lines_rpt)
	);

	tscu_sat_counter #(.WIDTH(COUNT_WIDTH)) u_blank (
		.clk(clk), .arst_n(arst_n),
		.inc(step && en_lines && en_q[tscu_pkg::EN_BLANK_BIT] && is_nl
			&& (last_line_q == tscu_pkg::NEWLINE_BYTE)),
		.clr(fin),
		.count(blank_cnt), .report(blank_rpt)
	);

	tscu_sat_counter #(.WIDTH(COUNT_WIDTH)) u_words (
		.clk(clk), .arst_n(arst_n),
		.inc(trk_evt.word_end), .clr(fin),
		.count(words_cnt), .report(words_rpt)
	);

	tscu_sat_counter #(.WIDTH(COUNT_WIDTH)) u_score (
		.clk(clk), .arst_n(arst_n),
		.inc(trk_evt.score), .clr(fin),
		.count(score_cnt), .report(score_rpt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			char_q   <= chars_rpt;
			line_q   <= lines_rpt;
			word_q   <= words_rpt;
			blank_q  <= blank_rpt;
			filled_q <= (lines_rpt >= blank_rpt) ? lines_rpt - blank_rpt
				: blank_rpt - lines_rpt;
			score_q  <= score_rpt;
		end
	end

	assign out_valid         = out_valid_q;
	assign char_count        = char_q;
	assign line_count        = line_q;
	assign word_count        = word_q;
	assign blank_line_count  = blank_q;
	assign filled_line_count = filled_q;
	assign pattern_score     = score_q;

	property p_finish_clears;
		@(posedge clk) disable iff (!arst_n)
		fin |=> (chars_cnt == '0) && (lines_cnt == '0) && (words_cnt == '0)
			&& (blank_cnt == '0) && (score_cnt == '0);
	endproperty
	a_finish_clears: assert property (p_finish_clears)
		else $error("counters not cleared after finish");

	property p_stall_only_on_finish;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |-> (cmd_s1 == tscu_pkg::CMD_FINISH) && out_valid_q;
	endproperty
	a_stall_only_on_finish: assert property (p_stall_only_on_finish)
		else $error("input stage stalled without a pending report");

	property p_report_from_finish;
		@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && (cmd_s1 == tscu_pkg::CMD_FINISH));
	endproperty
	a_report_from_finish: assert property (p_report_from_finish)
		else $error("report raised without a finish request");

	property p_empty_takes_input;
		@(posedge clk) disable iff (!arst_n) !valid_s1 |-> in_ready;
	endproperty
	a_empty_takes_input: assert property (p_empty_takes_input)
		else $error("empty input stage refusing requests");

endmodule

>>> hdl/tscu_sat_counter.sv
// saturating event counter with a 32-bit report view, clamped if wider, zero-extended if narrower
module tscu_sat_counter #(
	parameter int WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         inc,
	input  logic                         clr,
	output logic [WIDTH-1:0]             count,
	output logic [tscu_pkg::REPORT_W-1:0] report
);

	logic [WIDTH-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (inc && (count_q != {WIDTH{1'b1}})) begin
			count_q <= count_q + WIDTH'(1);
		end
	end

	assign count = count_q;

	generate
		if (WIDTH > tscu_pkg::REPORT_W) begin : g_clamp
			assign report = (|count_q[WIDTH-1:tscu_pkg::REPORT_W]) ?
				{tscu_pkg::REPORT_W{1'b1}} : count_q[tscu_pkg::REPORT_W-1:0];
		end else begin : g_extend
			assign report = tscu_pkg::REPORT_W'(count_q);
		end
	endgenerate

endmodule

>>> hdl/tscu_word_track.sv
// word boundary detection and pattern search over a sliding byte window
module tscu_word_track #(
	parameter int WIN_BYTES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tscu_pkg::trk_req_t               req,
	input  logic                             en_words,
	input  logic [tscu_pkg::LENGTH_W-1:0]    pattern_length,
	input  logic [tscu_pkg::PATTERN_W-1:0]   pattern,
	output tscu_pkg::trk_evt_t               evt
);

	localparam int FILL_W = $clog2(WIN_BYTES + 1);

	logic [7:0]        last_q;
	logic [7:0]        win_q [WIN_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic              has_q;

	logic [7:0]        nwin [WIN_BYTES];
	logic [FILL_W-1:0] nfill;
	logic [FILL_W-1:0] eff_len;
	logic              active;
	logic              sp_b;
	logic              word_end;
	logic              multi;
	logic              hit;

	assign eff_len = (pattern_length > tscu_pkg::LENGTH_W'(WIN_BYTES)) ?
		FILL_W'(WIN_BYTES) : pattern_length[FILL_W-1:0];
	assign active   = req.step && en_words;
	assign sp_b     = tscu_pkg::is_space(req.data);
	assign word_end = !tscu_pkg::is_space(last_q) && sp_b;
	assign multi    = eff_len > FILL_W'(1);
	assign nfill    = (fill_q < FILL_W'(WIN_BYTES)) ? fill_q + FILL_W'(1) : fill_q;

	always_comb begin
		for (int i = 0; i < WIN_BYTES - 1; i++) begin
			nwin[i] = win_q[i+1];
		end
		nwin[WIN_BYTES-1] = req.data;
	end

	// newest bytes of the window against the first bytes of the pattern
	always_comb begin
		logic mk;
		hit = 1'b0;
		for (int k = 2; k <= WIN_BYTES; k++) begin
			mk = 1'b1;
			for (int i = 0; i < k; i++) begin
				if (nwin[WIN_BYTES-k+i] != pattern[8*i +: 8]) begin
					mk = 1'b0;
				end
			end
			if (mk && (FILL_W'(k) == eff_len) && (nfill >= eff_len)) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			fill_q <= '0;
			has_q  <= 1'b0;
			for (int i = 0; i < WIN_BYTES; i++) begin
				win_q[i] <= '0;
			end
		end else if (req.clear) begin
			last_q <= '0;
			fill_q <= '0;
			has_q  <= 1'b0;
			for (int i = 0; i < WIN_BYTES; i++) begin
				win_q[i] <= '0;
			end
		end else if (active) begin
			last_q <= req.data;
			if (word_end && multi) begin
				fill_q <= '0;
				has_q  <= 1'b0;
				for (int i = 0; i < WIN_BYTES; i++) begin
					win_q[i] <= '0;
				end
			end else if (multi && !sp_b) begin
				win_q  <= nwin;
				fill_q <= nfill;
				if (hit) begin
					has_q <= 1'b1;
				end
			end
		end
	end

	assign evt.word_end = active && word_end;
	assign evt.score    = active && (((eff_len == FILL_W'(1)) && (req.data == pattern[7:0]))
		|| (word_end && multi && has_q));

	property p_fill_bounded;
		@(posedge clk) disable iff (!arst_n) fill_q <= FILL_W'(WIN_BYTES);
	endproperty
	a_fill_bounded: assert property (p_fill_bounded)
		else $error("window fill beyond window size");

	property p_clear_empties;
		@(posedge clk) disable iff (!arst_n) req.clear |=> (fill_q == '0) && !has_q;
	endproperty
	a_clear_empties: assert property (p_clear_empties)
		else $error("word state not cleared on finish");

	property p_has_needs_fill;
		@(posedge clk) disable iff (!arst_n) $rose(has_q) |-> fill_q >= FILL_W'(2);
	endproperty
	a_has_needs_fill: assert property (p_has_needs_fill)
		else $error("pattern flagged with too few bytes in window");

endmodule

>>> test/text_stream_statistics_counter_unit_tb.sv
// testbench for the text stream statistics counter with a built-in predictor
`timescale 1ns / 100ps

module text_stream_statistics_counter_unit_tb;
	import tscu_pkg::*;

	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 400;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_BYTES  = 56;

	typedef struct {
		cmd_t       op;
		logic [7:0] data;
	} text_req_t;

	typedef struct {
		logic [REPORT_W-1:0] chars;
		logic [REPORT_W-1:0] lines;
		logic [REPORT_W-1:0] words;
		logic [REPORT_W-1:0] blanks;
		logic [REPORT_W-1:0] filled;
		logic [REPORT_W-1:0] score;
	} tally_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   cmd;
	logic [7:0]             text_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic [REPORT_W-1:0]    char_count;
	logic [REPORT_W-1:0]    line_count;
	logic [REPORT_W-1:0]    word_count;
	logic [REPORT_W-1:0]    blank_line_count;
	logic [REPORT_W-1:0]    filled_line_count;
	logic [REPORT_W-1:0]    pattern_score;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [PATTERN_W-1:0]   cfg_data;

	text_req_t pending_reqs[$];
	tally_t    expected_tallies[$];

	// predictor copy of the registers and counting state
	logic [ENABLES_W-1:0] cur_en;
	logic [LENGTH_W-1:0]  cur_len;
	logic [PATTERN_W-1:0] cur_pat;
	logic [REPORT_W-1:0]  n_chars, n_lines, n_words, n_blanks, n_score;
	logic [7:0]           prev_line_byte, prev_word_byte;
	logic [PATTERN_W-1:0] word_win;
	logic [3:0]           win_fill;
	logic                 word_hit;

	int  tx_idle_pct;
	int  rx_idle_pct;
	bit  hold_go;
	bit  hold_done;
	int  hold_left;
	bit  in_taken;
	int  fail_count;
	int  reqs_taken;
	int  reports_checked;
	int  cfg_writes;
	int  quiet_cycles;

	text_stream_statistics_counter_unit u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cmd               (cmd),
		.text_byte         (text_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.char_count        (char_count),
		.line_count        (line_count),
		.word_count        (word_count),
		.blank_line_count  (blank_line_count),
		.filled_line_count (filled_line_count),
		.pattern_score     (pattern_score),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [REPORT_W-1:0] sat_inc(input logic [REPORT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic bit is_blank_char(input logic [7:0] b);
		return (b == SPACE_BYTE) || (b >= TAB_BYTE && b <= CR_BYTE);
	endfunction

	function automatic void clear_counts();
		n_chars        = '0;
		n_lines        = '0;
		n_words        = '0;
		n_blanks       = '0;
		n_score        = '0;
		prev_line_byte = '0;
		prev_word_byte = '0;
		word_win       = '0;
		win_fill       = '0;
		word_hit       = 1'b0;
	endfunction

	function automatic int live_len();
		return (cur_len > WINDOW_MAX_BYTES) ? WINDOW_MAX_BYTES : int'(cur_len);
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		int                   plen;
		logic [PATTERN_W-1:0] mask;
		logic [PATTERN_W-1:0] tail;
		plen = live_len();
		if (cur_en[EN_CHARS_BIT])
			n_chars = sat_inc(n_chars);
		if (cur_en[EN_LINES_BIT]) begin
			if (cur_en[EN_BLANK_BIT] && prev_line_byte == NEWLINE_BYTE && b == NEWLINE_BYTE)
				n_blanks = sat_inc(n_blanks);
			if (b == NEWLINE_BYTE)
				n_lines = sat_inc(n_lines);
			prev_line_byte = b;
		end
		if (cur_en[EN_WORDS_BIT]) begin
			if (plen == 1 && b == cur_pat[7:0])
				n_score = sat_inc(n_score);
			if (!is_blank_char(prev_word_byte) && is_blank_char(b)) begin
				n_words = sat_inc(n_words);
				if (plen > 1) begin
					if (word_hit)
						n_score = sat_inc(n_score);
					word_win = '0;
					win_fill = '0;
					word_hit = 1'b0;
				end
			end
			if (plen > 1 && !is_blank_char(b)) begin
				mask     = (plen >= WINDOW_MAX_BYTES) ? '1 : ((64'd1 << (8 * plen)) - 1);
				word_win = {b, word_win[PATTERN_W-1:8]};
				if (win_fill < WINDOW_MAX_BYTES)
					win_fill = win_fill + 1'b1;
				tail = word_win >> (PATTERN_W - 8 * plen);
				if (win_fill >= plen && tail == (cur_pat & mask))
					word_hit = 1'b1;
			end
			prev_word_byte = b;
		end
	endfunction

	function automatic void check_field(input string name, input logic [REPORT_W-1:0] want,
			input logic [REPORT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// prediction on accepted requests, checking on accepted reports
	always @(posedge clk) begin : monitor_proc
		tally_t t;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid || out_valid || cfg_valid)
				quiet_cycles = ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) ? 0 : quiet_cycles + 1;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				case (cfg_idx_t'(cfg_index))
					CFG_COUNT_ENABLES:  cur_en  = cfg_data[ENABLES_W-1:0];
					CFG_PATTERN_LENGTH: cur_len = cfg_data[LENGTH_W-1:0];
					CFG_PATTERN_BYTES:  cur_pat = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				reqs_taken++;
				if (cmd == CMD_FINISH) begin
					t.chars  = n_chars;
					t.lines  = n_lines;
					t.words  = n_words;
					t.blanks = n_blanks;
					t.filled = (n_lines >= n_blanks) ? n_lines - n_blanks : n_blanks - n_lines;
					t.score  = n_score;
					expected_tallies.push_back(t);
					clear_counts();
				end else begin
					absorb_byte(text_byte);
				end
			end
			if (out_valid && out_ready) begin
				if (expected_tallies.size() == 0) begin
					$error("report with no finish request outstanding");
					fail_count++;
				end else begin
					t = expected_tallies.pop_front();
					check_field("char_count", t.chars, char_count);
					check_field("line_count", t.lines, line_count);
					check_field("word_count", t.words, word_count);
					check_field("blank_line_count", t.blanks, blank_line_count);
					check_field("filled_line_count", t.filled, filled_line_count);
					check_field("pattern_score", t.score, pattern_score);
					reports_checked++;
				end
			end
		end
	end

	always @(negedge clk) begin : drive_proc
		text_req_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = pending_reqs.pop_front();
				in_valid  <= 1'b1;
				cmd       <= nxt.op;
				text_byte <= nxt.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : accept_proc
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic push_req(input cmd_t op, input logic [7:0] data);
		text_req_t r;
		r.op   = op;
		r.data = data;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_reqs.size() > 0 || in_valid || expected_tallies.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [PATTERN_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_cfg(input logic [3:0] en, input logic [3:0] len,
			input logic [PATTERN_W-1:0] pat);
		logic [PATTERN_W-1:0] junk;
		junk = {$urandom, $urandom};
		write_cfg(CFG_COUNT_ENABLES, {junk[PATTERN_W-1:4], en});
		junk = {$urandom, $urandom};
		write_cfg(CFG_PATTERN_LENGTH, {junk[PATTERN_W-1:4], len});
		write_cfg(CFG_PATTERN_BYTES, pat);
	endtask

	function automatic logic [7:0] blank_pick();
		case ($urandom_range(0, 5))
			0, 1:    return NEWLINE_BYTE;
			2:       return SPACE_BYTE;
			default: return TAB_BYTE + 8'($urandom_range(0, 4));
		endcase
	endfunction

	function automatic logic [PATTERN_W-1:0] make_pattern();
		logic [PATTERN_W-1:0] p;
		for (int i = 0; i < WINDOW_MAX_BYTES; i++) begin
			case ($urandom_range(0, 4))
				0:       p[8*i +: 8] = "a";
				1:       p[8*i +: 8] = "b";
				2:       p[8*i +: 8] = 8'h00;
				3:       p[8*i +: 8] = 8'hff;
				default: p[8*i +: 8] = 8'($urandom);
			endcase
		end
		return p;
	endfunction

	// words built from a small alphabet with the pattern spliced in, blank characters, finishes, plus some noise
	task automatic queue_text(input int n, input logic [PATTERN_W-1:0] pat, input int plen);
		int         pick;
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			b    = 8'($urandom);
			if (pick < 4) begin
				push_req(CMD_FINISH, b);
			end else if (pick < 22) begin
				push_req(CMD_BYTE, blank_pick());
			end else if (pick < 36 && plen > 0) begin
				for (int j = 0; j < plen; j++)
					push_req(CMD_BYTE, pat[8*j +: 8]);
			end else if (pick < 92) begin
				case ($urandom_range(0, 3))
					0:       push_req(CMD_BYTE, "a");
					1:       push_req(CMD_BYTE, "b");
					2:       push_req(CMD_BYTE, pat[7:0]);
					default: push_req(CMD_BYTE, pat[15:8]);
				endcase
			end else begin
				push_req(CMD_BYTE, b);
			end
		end
		push_req(CMD_FINISH, 8'($urandom));
	endtask

	initial begin
		logic [3:0]           en;
		logic [3:0]           len;
		logic [PATTERN_W-1:0] pat;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		cmd         = CMD_BYTE;
		text_byte   = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_COUNT_ENABLES;
		cfg_data    = '0;
		hold_go     = 1'b0;
		hold_done   = 1'b0;
		hold_left   = 0;
		in_taken    = 1'b0;
		fail_count  = 0;
		quiet_cycles = 0;
		cur_en      = 4'hf;
		cur_len     = '0;
		cur_pat     = '0;
		clear_counts();
		tx_idle_pct = 19;
		rx_idle_pct = 47;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: empty report, byte extremes, every blank character and the neighbours of tab to CR
		push_req(CMD_FINISH, 8'h00);
		push_req(CMD_BYTE, 8'h00);
		push_req(CMD_BYTE, 8'hff);
		push_req(CMD_BYTE, SPACE_BYTE);
		push_req(CMD_BYTE, NEWLINE_BYTE);
		push_req(CMD_BYTE, NEWLINE_BYTE);
		push_req(CMD_BYTE, TAB_BYTE);
		push_req(CMD_BYTE, 8'h08);
		push_req(CMD_BYTE, CR_BYTE);
		push_req(CMD_BYTE, 8'h0e);
		push_req(CMD_BYTE, 8'h0b);
		push_req(CMD_BYTE, 8'h0c);
		push_req(CMD_BYTE, "w");
		push_req(CMD_FINISH, 8'hff);
		wait_idle();

		// previous bytes held while line or word counting is switched off
		push_req(CMD_BYTE, NEWLINE_BYTE);
		wait_idle();
		write_cfg(CFG_COUNT_ENABLES, 64'h0b);
		push_req(CMD_BYTE, "a");
		wait_idle();
		write_cfg(CFG_COUNT_ENABLES, 64'h0f);
		push_req(CMD_BYTE, NEWLINE_BYTE);
		push_req(CMD_BYTE, "b");
		wait_idle();
		write_cfg(CFG_COUNT_ENABLES, 64'h0d);
		push_req(CMD_BYTE, SPACE_BYTE);
		wait_idle();
		write_cfg(CFG_COUNT_ENABLES, 64'h0f);
		push_req(CMD_BYTE, SPACE_BYTE);
		push_req(CMD_FINISH, 8'h5a);
		wait_idle();

		for (int k = 0; k < NUM_PHASES; k++) begin
			if (k == 4) begin
				tx_idle_pct = 47;
				rx_idle_pct = 19;
			end else if (k == 8) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			pat = make_pattern();
			case (k)
				0:       begin en = 4'hf; len = 4'd1; end
				1:       begin en = 4'hf; len = 4'd2; end
				2:       begin en = 4'hf; len = 4'd8; end
				3:       begin en = 4'h0; len = 4'd3; end
				4:       begin en = 4'hf; len = 4'hf; pat = '1; end
				5:       begin en = 4'ha; len = 4'd4; end
				6:       begin en = 4'h5; len = 4'd1; end
				7:       begin en = 4'hf; len = 4'd0; pat = '0; end
				8:       begin en = 4'he; len = 4'd5; pat[15:8] = 8'h00; end
				default: begin en = 4'($urandom); len = 4'($urandom); end
			endcase
			set_cfg(en, len, pat);
			if (k == 9) begin
				hold_go = 1'b1;
				// a held report and a second finish behind it stall the text that follows
				push_req(CMD_FINISH, 8'h00);
				push_req(CMD_FINISH, 8'h00);
			end
			queue_text(PHASE_BYTES, pat, (len > WINDOW_MAX_BYTES) ? WINDOW_MAX_BYTES : int'(len));
			wait_idle();
		end

		$display("run took %0d requests, checked %0d reports, made %0d register writes",
			reqs_taken, reports_checked, cfg_writes);
		$display("covered blank and word edges, one-byte and in-word patterns, enable mixes");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
